/* hdl/sfr_pkg.sv */
`default_nettype none
package sfr_pkg;

   // frame geometry
   localparam int FRAME_BYTES = 32;
   localparam int RAW_WORDS   = (FRAME_BYTES - 6) / 2;
   localparam int DATA_WORDS  = (RAW_WORDS > 13) ? 13 : RAW_WORDS;
   localparam int CNT_W       = $clog2(FRAME_BYTES);
   localparam int MEM_AW      = CNT_W - 1;
   localparam int MEM_WORDS   = (FRAME_BYTES + 1) / 2;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int IDX_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   // first data word sits at byte 4, word address 2
   localparam logic [MEM_AW-1:0] FIRST_WORD_ADDR = MEM_AW'(2);
   localparam logic [IDX_W-1:0]  LAST_WORD_IDX   = IDX_W'(DATA_WORDS - 1);

   // header bytes and register reset values
   localparam logic [BYTE_W-1:0] HDR_FIRST     = 8'h42;
   localparam logic [BYTE_W-1:0] HDR_SECOND    = 8'h4D;
   localparam logic [WORD_W-1:0] RESET_TIMEOUT = 16'd10000;
   localparam logic [WORD_W-1:0] RESET_LENGTH  = 16'd28;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      RS_GOOD     = 2'd0,
      RS_BAD_LEN  = 2'd1,
      RS_BAD_SUM  = 2'd2,
      RS_TIMEOUT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_HUNT_FIRST  = 2'd0,
      PH_HUNT_SECOND = 2'd1,
      PH_COLLECT     = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CS_IDLE = 2'd0,
      CS_READ = 2'd1,
      CS_LOAD = 2'd2
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic              take_item;
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
      logic              load_word;
      logic [IDX_W-1:0]  word_idx;
      logic              word_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic frame_good;
   } stat_type;

endpackage
`default_nettype wire

/* hdl/sensor_frame_receiver.sv */
`default_nettype none
// Channel  Dir  Handshake                Payload
// req      in   req_tvalid/req_tready    tuser: kind; tdata: rx_byte
// rsp      out  rsp_tvalid/rsp_tready    tuser: status; tdata: word_index, word_value;
//                                        tlast: last
// csr      in   csr_valid/csr_ready      csr_index, csr_data
//
// A byte or tick request is taken in the idle state when the output register is free.
// The final byte of a good frame starts a readout of the stored data words from a
// word memory (13 words for a 32-byte frame): each word is read, then loaded when
// the output register is free, and no request is taken until the last word is loaded.
// Synchronous reset clears counters, phase and control state, not the payload registers
// or frame memory. A stalled rsp_tready holds the output register and blocks requests.
module sensor_frame_receiver
   import sfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  wire logic                   req_tuser,   // [0] kind
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // [3:0] word_index, [19:4] word_value
   output logic [STATUS_W-1:0]         rsp_tuser,   // [1:0] status
   output logic                        rsp_tlast,   // last
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [WORD_W-1:0]      csr_data
);

   cmd_type           cmd;
   stat_type          stat;
   logic [IDX_W-1:0]  rsp_idx;
   logic [WORD_W-1:0] rsp_value;

   assign csr_ready = 1'b1;

   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser),
      .req_byte   (req_tdata[BYTE_W-1:0]),
      .cmd        (cmd),
      .stat       (stat),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_idx    (rsp_idx),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {{(RSP_TDATA_W - IDX_W - WORD_W){1'b0}}, rsp_value, rsp_idx};

endmodule
`default_nettype wire

/* hdl/sfr_ctrl.sv */
`default_nettype none
module sfr_ctrl
   import sfr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] word_ff, word_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      req_tready    = 1'b0;
      cmd.take_item = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.rd_addr   = FIRST_WORD_ADDR + MEM_AW'(word_ff);
      cmd.load_word = 1'b0;
      cmd.word_idx  = word_ff;
      cmd.word_last = (word_ff == LAST_WORD_IDX);
      unique case (state_ff)
         CS_IDLE: begin
            // a request may produce a result, so the output register must be free
            req_tready    = stat.out_free;
            cmd.take_item = req_tvalid && stat.out_free;
            if (cmd.take_item && stat.frame_good) begin
               word_in  = '0;
               state_in = CS_READ;
            end
         end
         CS_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = CS_LOAD;
         end
         CS_LOAD: begin
            if (stat.out_free) begin
               cmd.load_word = 1'b1;
               if (word_ff == LAST_WORD_IDX) begin
                  state_in = CS_IDLE;
               end else begin
                  word_in  = word_ff + 1'b1;
                  state_in = CS_READ;
               end
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hdl/sfr_dpath.sv */
`default_nettype none
module sfr_dpath
   import sfr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_kind,
   input  wire logic [BYTE_W-1:0]    req_byte,
   input  wire cmd_type              cmd,
   output stat_type                  stat,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data,
   input  wire logic                 rsp_tready,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [IDX_W-1:0]          rsp_idx,
   output logic [WORD_W-1:0]         rsp_value,
   output logic                      rsp_last
);

   // frame state
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [WORD_W-1:0] tick_ff, tick_in;
   logic [WORD_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] hi_ff, hi_in;
   logic [WORD_W-1:0] timeout_ff, timeout_in;
   logic [WORD_W-1:0] length_ff, length_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [WORD_W-1:0] out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;

   // word store, high byte first
   logic [WORD_W-1:0] mem [MEM_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;

   logic [WORD_W-1:0] tick_inc;
   logic [WORD_W-1:0] limit;
   logic              timeout_hit;
   logic              is_final;
   logic [WORD_W-1:0] rx_word;
   logic              len_bad;
   logic              sum_bad;
   logic              res_load;
   status_type        res_status;
   logic [WORD_W-1:0] res_value;

   assign tick_inc    = tick_ff + 1'b1;
   assign limit       = (timeout_ff == '0) ? WORD_W'(1) : timeout_ff;
   assign timeout_hit = (tick_inc >= limit);
   assign is_final    = !req_kind && (phase_ff == PH_COLLECT) &&
                        (count_ff == CNT_W'(FRAME_BYTES - 1));
   assign rx_word     = {hi_ff, req_byte};
   assign len_bad     = (len_ff != length_ff);
   assign sum_bad     = (sum_ff != rx_word);

   assign stat.out_free   = !out_valid_ff || rsp_tready;
   assign stat.frame_good = is_final && !len_bad && !sum_bad;

   // frame parsing
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      tick_in    = tick_ff;
      len_in     = len_ff;
      hi_in      = hi_ff;
      mem_we     = 1'b0;
      res_load   = 1'b0;
      res_status = RS_TIMEOUT;
      res_value  = '0;
      if (cmd.take_item) begin
         if (req_kind) begin
            if (timeout_hit) begin
               res_load   = 1'b1;
               res_status = RS_TIMEOUT;
               res_value  = (phase_ff == PH_HUNT_SECOND || phase_ff == PH_COLLECT) ?
                            WORD_W'(count_ff) : '0;
               phase_in   = PH_HUNT_FIRST;
               count_in   = '0;
               sum_in     = '0;
               tick_in    = '0;
            end else begin
               tick_in = tick_inc;
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT_SECOND: begin
                  // a wrong second byte is not retried as a first byte
                  if (req_byte == HDR_SECOND) begin
                     phase_in = PH_COLLECT;
                     count_in = CNT_W'(2);
                     sum_in   = WORD_W'(HDR_FIRST) + WORD_W'(HDR_SECOND);
                  end else begin
                     phase_in = PH_HUNT_FIRST;
                     count_in = '0;
                  end
               end
               PH_COLLECT: begin
                  hi_in  = req_byte;
                  mem_we = count_ff[0];
                  if (count_ff == CNT_W'(3)) begin
                     len_in = rx_word;
                  end
                  if (count_ff < CNT_W'(FRAME_BYTES - 2)) begin
                     sum_in = sum_ff + WORD_W'(req_byte);
                  end
                  if (is_final) begin
                     phase_in = PH_HUNT_FIRST;
                     count_in = '0;
                     sum_in   = '0;
                     tick_in  = '0;
                     if (len_bad) begin
                        res_load   = 1'b1;
                        res_status = RS_BAD_LEN;
                        res_value  = len_ff;
                     end else if (sum_bad) begin
                        res_load   = 1'b1;
                        res_status = RS_BAD_SUM;
                        res_value  = sum_ff;
                     end
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               default: begin
                  if (req_byte == HDR_FIRST) begin
                     phase_in = PH_HUNT_SECOND;
                     count_in = CNT_W'(1);
                  end else begin
                     phase_in = PH_HUNT_FIRST;
                     count_in = '0;
                  end
               end
            endcase
         end
      end
   end

   // register writes
   always_comb begin
      timeout_in = timeout_ff;
      length_in  = length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_data;
            CSR_LENGTH:  length_in  = csr_data;
         endcase
      end
   end

   // output register load
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_idx_in    = out_idx_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      priority if (res_load) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status;
         out_idx_in    = '0;
         out_value_in  = res_value;
         out_last_in   = 1'b1;
      end else if (cmd.load_word) begin
         out_valid_in  = 1'b1;
         out_status_in = RS_GOOD;
         out_idx_in    = cmd.word_idx;
         out_value_in  = rd_data_ff;
         out_last_in   = cmd.word_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT_FIRST;
         count_ff     <= '0;
         sum_ff       <= '0;
         tick_ff      <= '0;
         timeout_ff   <= RESET_TIMEOUT;
         length_ff    <= RESET_LENGTH;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         tick_ff      <= tick_in;
         timeout_ff   <= timeout_in;
         length_ff    <= length_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      hi_ff         <= hi_in;
      out_status_ff <= out_status_in;
      out_idx_ff    <= out_idx_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   // word memory: written on each odd byte, read one word per controller read command
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[CNT_W-1:1]] <= rx_word;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_idx    = out_idx_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_last   = out_last_ff;

endmodule
`default_nettype wire

/* bench/sfr_frame_checker.sv */
`default_nettype none
module sfr_frame_checker
   import sfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic [STATUS_W-1:0]    rsp_tuser,
   input  wire logic                   rsp_tlast,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [WORD_W-1:0]      csr_data,
   output int                          fail_count,
   output int                          pending,
   output int                          checked_count,
   output int                          good_frames
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type         status;
      logic [IDX_W-1:0]   idx;
      logic [WORD_W-1:0]  value;
      logic               last;
   } frame_result_type;

   // results still owed by the block, oldest first
   frame_result_type expected_words[$];

   // shadow registers and receiver state
   logic [WORD_W-1:0] timeout_reg;
   logic [WORD_W-1:0] length_reg;
   phase_type         phase;
   int unsigned       held;
   logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
   logic [WORD_W-1:0] byte_sum;
   logic [WORD_W-1:0] ticks;

   function automatic void restart_hunt();
      phase    = PH_HUNT_FIRST;
      held     = 0;
      byte_sum = '0;
      ticks    = '0;
   endfunction

   function automatic void owe_result(status_type s, int unsigned idx,
                                      logic [WORD_W-1:0] v, logic last);
      frame_result_type r;
      r.status = s;
      r.idx    = IDX_W'(idx);
      r.value  = v;
      r.last   = last;
      expected_words.push_back(r);
   endfunction

   // big-endian word from two stored bytes
   function automatic logic [WORD_W-1:0] word_at(int unsigned pos);
      return {frame_bytes[pos], frame_bytes[pos+1]};
   endfunction

   // advance the receiver by one byte or tick, queueing what it emits
   function automatic void decode_item(logic kind, logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] limit;
      logic [WORD_W-1:0] len_word;
      logic [WORD_W-1:0] sum_word;
      logic [WORD_W-1:0] collected;
      int unsigned       pos;
      int unsigned       n;
      if (kind) begin
         // a zero timeout behaves like one
         limit = (timeout_reg == '0) ? WORD_W'(1) : timeout_reg;
         ticks = ticks + 1'b1;
         if (ticks >= limit) begin
            collected = (phase == PH_HUNT_SECOND || phase == PH_COLLECT) ?
                        WORD_W'(held) : '0;
            owe_result(RS_TIMEOUT, 0, collected, 1'b1);
            restart_hunt();
         end
      end else if (phase == PH_HUNT_SECOND) begin
         // a wrong second byte drops back to hunting, not re-tried as a first byte
         if (b == HDR_SECOND) begin
            frame_bytes[1] = b;
            held           = 2;
            byte_sum       = WORD_W'(HDR_FIRST) + WORD_W'(HDR_SECOND);
            phase          = PH_COLLECT;
         end else begin
            phase = PH_HUNT_FIRST;
            held  = 0;
         end
      end else if (phase == PH_COLLECT) begin
         pos = held;
         if (pos < 2 || pos >= FRAME_BYTES) begin
            restart_hunt();
         end else begin
            frame_bytes[pos] = b;
            if (pos < FRAME_BYTES - 2)
               byte_sum = byte_sum + WORD_W'(b);
            if (pos + 1 < FRAME_BYTES) begin
               held = pos + 1;
            end else begin
               // frame complete: length first, then checksum
               len_word = word_at(2);
               sum_word = word_at(FRAME_BYTES - 2);
               if (len_word != length_reg)
                  owe_result(RS_BAD_LEN, 0, len_word, 1'b1);
               else if (byte_sum != sum_word)
                  owe_result(RS_BAD_SUM, 0, byte_sum, 1'b1);
               else
                  for (n = 0; n < DATA_WORDS; n++)
                     owe_result(RS_GOOD, n, word_at(4 + 2*n), n == DATA_WORDS - 1);
               restart_hunt();
            end
         end
      end else begin
         if (b == HDR_FIRST) begin
            frame_bytes[0] = b;
            held           = 1;
            phase          = PH_HUNT_SECOND;
         end else begin
            phase = PH_HUNT_FIRST;
            held  = 0;
         end
      end
   endfunction

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      frame_result_type  want;
      logic [IDX_W-1:0]  got_idx;
      logic [WORD_W-1:0] got_value;
      logic [3:0]        got_pad;
      if (reset) begin
         timeout_reg = RESET_TIMEOUT;
         length_reg  = RESET_LENGTH;
         restart_hunt();
         expected_words.delete();
         fail_count    = 0;
         checked_count = 0;
         good_frames   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIMEOUT: timeout_reg = csr_data;
               CSR_LENGTH:  length_reg  = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            decode_item(req_tuser, req_tdata[BYTE_W-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            got_idx   = rsp_tdata[IDX_W-1:0];
            got_value = rsp_tdata[IDX_W +: WORD_W];
            got_pad   = rsp_tdata[RSP_TDATA_W-1 -: 4];
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result status %0d idx %0d value %h last %b",
                           $realtime, rsp_tuser, got_idx, got_value, rsp_tlast);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tuser != want.status || got_idx != want.idx ||
                   got_value != want.value || rsp_tlast != want.last ||
                   got_pad != '0) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $write("%0t: mismatch, expected status %0d idx %0d value %h last %b, ",
                            $realtime, want.status, want.idx, want.value, want.last);
                     $display("got status %0d idx %0d value %h last %b pad %h",
                              rsp_tuser, got_idx, got_value, rsp_tlast, got_pad);
                  end
               end else if (want.status == RS_GOOD && want.last) begin
                  good_frames++;
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule
`default_nettype wire

/* bench/tb_sensor_frame_receiver.sv */
`default_nettype none
module tb_sensor_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   typedef enum int {
      FLAW_NONE,
      FLAW_LENGTH,
      FLAW_SUM,
      FLAW_SHORT
   } flaw_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire [RSP_TDATA_W-1:0]  rsp_tdata;
   wire [STATUS_W-1:0]     rsp_tuser;
   wire                    rsp_tlast;
   logic                   csr_valid  = 1'b0;
   wire                    csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_TIMEOUT;
   logic [WORD_W-1:0]      csr_data   = '0;

   int                     fail_count;
   int                     pending;
   int                     checked_count;
   int                     good_frames;

   // stimulus bookkeeping
   int                     items_sent = 0;
   logic [WORD_W-1:0]      length_now = RESET_LENGTH;
   bit                     calm       = 1'b0;

   sensor_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sfr_frame_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .good_frames   (good_frames)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 9);
   end

   // one byte or tick request, held until taken
   task automatic put_item(input logic kind, input logic [BYTE_W-1:0] b);
      if (!calm && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // tick carries a random byte that the block must ignore
   task automatic send_tick();
      put_item(1'b1, BYTE_W'($urandom));
   endtask

   task automatic send_noise(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(9);
         if (pick == 0)
            send_tick();
         else if (pick == 1)
            put_item(1'b0, HDR_FIRST);
         else if (pick == 2)
            put_item(1'b0, HDR_SECOND);
         else
            put_item(1'b0, BYTE_W'($urandom));
      end
   endtask

   // build a frame with the given flaw; fill < 0 means random payload
   task automatic send_frame(input flaw_type flaw, input int tick_pct, input int fill);
      logic [BYTE_W-1:0] frame [FRAME_BYTES];
      logic [WORD_W-1:0] len_word;
      logic [WORD_W-1:0] sum;
      int                stop;
      len_word = length_now;
      if (flaw == FLAW_LENGTH)
         len_word = length_now ^ WORD_W'($urandom_range(1, 65535));
      frame[0] = HDR_FIRST;
      frame[1] = HDR_SECOND;
      frame[2] = len_word[15:8];
      frame[3] = len_word[7:0];
      for (int i = 4; i < FRAME_BYTES - 2; i++)
         frame[i] = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
      sum = '0;
      for (int i = 0; i < FRAME_BYTES - 2; i++)
         sum = sum + WORD_W'(frame[i]);
      if (flaw == FLAW_SUM)
         sum = sum + WORD_W'($urandom_range(1, 65535));
      frame[FRAME_BYTES-2] = sum[15:8];
      frame[FRAME_BYTES-1] = sum[7:0];
      stop = (flaw == FLAW_SHORT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
      for (int i = 0; i < stop; i++) begin
         if ($urandom_range(99) < tick_pct)
            send_tick();
         put_item(1'b0, frame[i]);
      end
   endtask

   // register write once all owed results are out and the readout has settled
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_LENGTH)
         length_now = value;
   endtask

   // one register setting with a random mix of frames and line noise
   task automatic run_phase(input logic [WORD_W-1:0] timeout_val,
                            input logic [WORD_W-1:0] length_val,
                            input int tick_pct, input int budget);
      int start;
      int pick;
      write_reg(CSR_TIMEOUT, timeout_val);
      write_reg(CSR_LENGTH, length_val);
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_frame(FLAW_NONE, tick_pct, -1);
         else if (pick < 68)
            send_frame(FLAW_LENGTH, tick_pct, -1);
         else if (pick < 81)
            send_frame(FLAW_SUM, tick_pct, -1);
         else if (pick < 90)
            send_frame(FLAW_SHORT, tick_pct, -1);
         else
            send_noise($urandom_range(1, 6));
      end
   endtask

   // stimulus and verdict
   initial begin
      int waited;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // repeated first header byte is not retried; stray second byte ignored
      put_item(1'b0, HDR_FIRST);
      put_item(1'b0, HDR_FIRST);
      put_item(1'b0, HDR_SECOND);
      send_tick();
      // payload extremes, then a length error and a checksum error
      send_frame(FLAW_NONE, 0, 255);
      send_frame(FLAW_NONE, 0, 0);
      send_frame(FLAW_LENGTH, 0, -1);
      send_frame(FLAW_SUM, 0, -1);

      // zero timeout: every tick reports, with the bytes held so far
      write_reg(CSR_TIMEOUT, 16'd0);
      send_tick();
      put_item(1'b0, HDR_FIRST);
      send_tick();
      put_item(1'b0, HDR_FIRST);
      put_item(1'b0, HDR_SECOND);
      put_item(1'b0, 8'h00);
      put_item(1'b0, 8'h1C);
      put_item(1'b0, 8'hA5);
      send_tick();

      run_phase(16'd0, 16'd0, 1, 50);
      run_phase(16'd1, 16'hFFFF, 1, 50);
      run_phase(WORD_W'($urandom_range(30, 90)), WORD_W'($urandom), 6, 50);
      calm = 1'b1;
      run_phase(16'hFFFF, RESET_LENGTH, 3, 50);

      // drain
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (40) @(negedge clock);

      $display("covered %0d byte/tick requests over six register settings", items_sent);
      $display("checked %0d results, %0d good frames read out", checked_count, good_frames);
      if (pending != 0)
         $display("%0d results never arrived", pending);
      if (fail_count == 0 && pending == 0)
         $display("sensor_frame_receiver regression: pass");
      else
         $display("sensor_frame_receiver regression: fail");
      $finish;
   end

   // hang guard
   initial begin
      #5ms;
      $display("sensor_frame_receiver regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
hdl/sfr_pkg.sv
hdl/sfr_ctrl.sv
hdl/sfr_dpath.sv
hdl/sensor_frame_receiver.sv
bench/sfr_frame_checker.sv
bench/tb_sensor_frame_receiver.sv
